### rtl/anxb_pkg.sv
package anxb_pkg;

  // Width of the per-unit byte counter; the count saturates at its maximum.
  localparam int unsigned LENGTH_BITS = 24;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // Width of the reported length field.
  localparam int unsigned OUT_LEN_W = 24;

  // Start code sizes in bytes.
  localparam logic [2:0] SC_SIZE_3 = 3'd3;
  localparam logic [2:0] SC_SIZE_4 = 3'd4;

  // NAL header bytes that select a class.
  localparam logic [7:0] HDR_SPS = 8'h67;
  localparam logic [7:0] HDR_PPS = 8'h68;
  localparam logic [7:0] HDR_SEI = 8'h06;
  localparam logic [7:0] HDR_IDR = 8'h65;
  localparam logic [7:0] HDR_P   = 8'h41;
  localparam logic [7:0] HDR_B   = 8'h01;

  typedef enum logic [2:0] {
    CLASS_UNKNOWN = 3'd0,
    CLASS_SPS     = 3'd1,
    CLASS_PPS     = 3'd2,
    CLASS_SEI     = 3'd3,
    CLASS_IDR     = 3'd4,
    CLASS_P       = 3'd5,
    CLASS_B       = 3'd6
  } unit_class_t;

  function automatic unit_class_t classify(input logic [7:0] hdr);
    unit_class_t cls;
    case (hdr)
      HDR_SPS: cls = CLASS_SPS;
      HDR_PPS: cls = CLASS_PPS;
      HDR_SEI: cls = CLASS_SEI;
      HDR_IDR: cls = CLASS_IDR;
      HDR_P:   cls = CLASS_P;
      HDR_B:   cls = CLASS_B;
      default: cls = CLASS_UNKNOWN;
    endcase
    return cls;
  endfunction

endpackage

### rtl/anxb_if.sv
// Input channel: one stream byte per item.
interface anxb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Output channel: one finished NAL unit per item.
interface anxb_unit_if;
  logic                           valid;
  logic                           ready;
  logic [anxb_pkg::OUT_LEN_W-1:0] unit_length;
  logic [2:0]                     unit_class;
  logic [2:0]                     start_code_size;
  logic                           length_saturated;

  modport source (output valid, output unit_length, output unit_class,
                  output start_code_size, output length_saturated, input ready);
  modport sink (input valid, input unit_length, input unit_class,
                input start_code_size, input length_saturated, output ready);
endinterface

### rtl/annexb_nal_splitter_unit.sv
// Splits an H.264 Annex B elementary stream, fed one byte per item, into NAL
// units and emits one item per finished unit carrying its length (its own
// start code included), a class taken from the byte right after the start
// code, the size of that start code (3 or 4) and a flag that is set when the
// length counter saturated and the length was clamped. Two zeros and a 0x01
// form a 3-byte start code; three or more zeros and a 0x01 form a 4-byte one,
// and any zeros beyond three stay with the previous unit. Bytes before the
// first start code are dropped. A byte marked last flushes the open unit and
// returns the block to its reset state; if that byte completes a start code,
// the unit it ends is reported and the empty new unit is discarded. The block
// takes one byte every cycle: each byte passes through an input register and
// a single step of scanner logic into the result register, from which the
// finished unit is offered to the downstream side. The only thing that slows
// the input is a result register that is full and not being taken by the
// downstream side.
module annexb_nal_splitter_unit (
  input logic       clk,
  input logic       rst,
  anxb_byte_if.sink bytes,
  anxb_unit_if.source units
);
  import anxb_pkg::*;

  // Input register stage.
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;

  // Scanner state.
  logic [1:0]             zero_run;
  logic                   inside_unit;
  logic                   header_pending;
  logic [LENGTH_BITS-1:0] byte_count;
  unit_class_t            current_class;
  logic [2:0]             current_start_size;
  logic                   count_overflow;

  logic [1:0]             zero_run_next;
  logic                   inside_unit_next;
  logic                   header_pending_next;
  logic [LENGTH_BITS-1:0] byte_count_next;
  unit_class_t            current_class_next;
  logic [2:0]             current_start_size_next;
  logic                   count_overflow_next;

  // Result register.
  logic                   res_valid;
  logic [OUT_LEN_W-1:0]   res_length;
  unit_class_t            res_class;
  logic [2:0]             res_size;
  logic                   res_sat;

  logic                   emit;
  logic [LENGTH_BITS-1:0] emit_length;
  unit_class_t            emit_class;
  logic [2:0]             emit_size;
  logic                   emit_sat;

  logic                   res_free;
  logic                   s1_fire;
  logic                   start;
  logic                   long_code;
  logic [LENGTH_BITS-1:0] code_zeros;

  // The result register can be written when it is empty or being drained;
  // the input stage moves on exactly then, so one byte flows per cycle.
  assign res_free    = !res_valid || units.ready;
  assign s1_fire     = s1_valid && res_free;
  assign bytes.ready = !s1_valid || res_free;

  assign start      = (s1_data == 8'h01) && zero_run[1];
  assign long_code  = (zero_run == 2'd3);
  assign code_zeros = long_code ? LENGTH_BITS'(3) : LENGTH_BITS'(2);

  always_comb begin
    zero_run_next           = zero_run;
    inside_unit_next        = inside_unit;
    header_pending_next     = header_pending;
    byte_count_next         = byte_count;
    current_class_next      = current_class;
    current_start_size_next = current_start_size;
    count_overflow_next     = count_overflow;
    emit                    = 1'b0;
    emit_length             = byte_count;
    emit_class              = current_class;
    emit_size               = current_start_size;
    emit_sat                = count_overflow;

    if (start) begin
      // A start code closes the open unit; its trailing zeros belong to the
      // new code, so they come off the old unit's length.
      if (inside_unit) begin
        emit = 1'b1;
        if (count_overflow) begin
          emit_length = LEN_MAX;
        end else if (byte_count >= code_zeros) begin
          emit_length = byte_count - code_zeros;
        end else begin
          emit_length = '0;
        end
      end
      inside_unit_next        = 1'b1;
      header_pending_next     = 1'b1;
      byte_count_next         = long_code ? LENGTH_BITS'(4) : LENGTH_BITS'(3);
      current_class_next      = CLASS_UNKNOWN;
      current_start_size_next = long_code ? SC_SIZE_4 : SC_SIZE_3;
      count_overflow_next     = 1'b0;
      zero_run_next           = 2'd0;
    end else begin
      if (s1_data == 8'h00) begin
        if (zero_run != 2'd3) begin
          zero_run_next = zero_run + 2'd1;
        end
      end else begin
        zero_run_next = 2'd0;
      end
      if (inside_unit) begin
        if (byte_count == LEN_MAX) begin
          count_overflow_next = 1'b1;
        end else begin
          byte_count_next = byte_count + 1'b1;
        end
        if (header_pending) begin
          current_class_next  = classify(s1_data);
          header_pending_next = 1'b0;
        end
      end
    end

    if (s1_last) begin
      // The final byte flushes the open unit with its updated totals.
      if (!start && inside_unit) begin
        emit        = 1'b1;
        emit_length = byte_count_next;
        emit_class  = current_class_next;
        emit_size   = current_start_size_next;
        emit_sat    = count_overflow_next;
      end
      zero_run_next           = 2'd0;
      inside_unit_next        = 1'b0;
      header_pending_next     = 1'b0;
      byte_count_next         = '0;
      current_class_next      = CLASS_UNKNOWN;
      current_start_size_next = SC_SIZE_3;
      count_overflow_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      res_valid          <= 1'b0;
      zero_run           <= 2'd0;
      inside_unit        <= 1'b0;
      header_pending     <= 1'b0;
      byte_count         <= '0;
      current_class      <= CLASS_UNKNOWN;
      current_start_size <= SC_SIZE_3;
      count_overflow     <= 1'b0;
    end else begin
      if (bytes.ready) begin
        s1_valid <= bytes.valid;
      end
      if (res_free) begin
        res_valid <= s1_fire && emit;
      end
      if (s1_fire) begin
        zero_run           <= zero_run_next;
        inside_unit        <= inside_unit_next;
        header_pending     <= header_pending_next;
        byte_count         <= byte_count_next;
        current_class      <= current_class_next;
        current_start_size <= current_start_size_next;
        count_overflow     <= count_overflow_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_data <= bytes.data_byte;
      s1_last <= bytes.last_byte;
    end
    if (s1_fire && emit) begin
      res_length <= OUT_LEN_W'(emit_length);
      res_class  <= emit_class;
      res_size   <= emit_size;
      res_sat    <= emit_sat;
    end
  end

  assign units.valid            = res_valid;
  assign units.unit_length      = res_length;
  assign units.unit_class       = res_class;
  assign units.start_code_size  = res_size;
  assign units.length_saturated = res_sat;

  // A header can only be awaited inside an open unit.
  a_header_in_unit: assert property (@(posedge clk) disable iff (rst)
    header_pending |-> inside_unit)
    else $error("header pending outside a unit");

  // An open unit always holds at least its 3-byte start code.
  a_count_floor: assert property (@(posedge clk) disable iff (rst)
    inside_unit |-> (byte_count >= LENGTH_BITS'(3)))
    else $error("open unit shorter than a start code");

  // A reported unit carries a legal start code size.
  a_result_size: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_size == SC_SIZE_3 || res_size == SC_SIZE_4))
    else $error("result with illegal start code size");

  // After the final byte is processed the scanner is back at reset.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (!inside_unit && zero_run == 2'd0 && !count_overflow))
    else $error("scanner not cleared after final byte");

endmodule
